### design/cfa_pkg.sv
`default_nettype none

package cfa_pkg;

   // Default geometry of the angle path and the rotation unit
   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int ANGLE_WIDTH_DEF     = 20;
   localparam int CORDIC_STEPS_DEF    = 16;

   // Raw sensor sample width
   localparam int SAMPLE_W = 16;

   // Register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_WEIGHT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_STEP_SCALE = 2'd1;

   localparam logic [CSR_DATA_W-1:0] BLEND_WEIGHT_RST    = 16'd58982;
   localparam logic [CSR_DATA_W-1:0] RATE_STEP_SCALE_RST = 16'd328;

   // Weight and scale are Q0.16; the angle accumulator works in Q.16 degrees
   localparam int Q16_FRAC = 16;

   // Arctangent table: atan(2^-i) in Q.16 degrees
   localparam int TAB_LEN   = 24;
   localparam int TAB_IDX_W = 5;
   localparam int ATAN_W    = 22;

   // 180 degrees in Q.16
   localparam int DEG180_Q16 = 11796480;

   typedef enum logic [1:0] {
      AXIS_ROLL  = 2'd0,
      AXIS_PITCH = 2'd1,
      AXIS_YAW   = 2'd2
   } axis_type;

   // Controller to datapath commands
   typedef struct packed {
      logic                 load;
      logic                 rot;
      logic                 dif;
      logic                 mul;
      logic                 acc;
      logic                 out_load;
      logic [TAB_IDX_W-1:0] step;
      axis_type             axis;
   } cmd_type;

   function automatic logic [ATAN_W-1:0] atan_q16(input logic [TAB_IDX_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      unique case (idx)
         5'd0:    val = 22'd2949120;
         5'd1:    val = 22'd1740967;
         5'd2:    val = 22'd919879;
         5'd3:    val = 22'd466945;
         5'd4:    val = 22'd234379;
         5'd5:    val = 22'd117304;
         5'd6:    val = 22'd58666;
         5'd7:    val = 22'd29335;
         5'd8:    val = 22'd14668;
         5'd9:    val = 22'd7334;
         5'd10:   val = 22'd3667;
         5'd11:   val = 22'd1833;
         5'd12:   val = 22'd917;
         5'd13:   val = 22'd458;
         5'd14:   val = 22'd229;
         5'd15:   val = 22'd115;
         5'd16:   val = 22'd57;
         5'd17:   val = 22'd29;
         5'd18:   val = 22'd14;
         5'd19:   val = 22'd7;
         5'd20:   val = 22'd4;
         5'd21:   val = 22'd2;
         5'd22:   val = 22'd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

### design/cfa_dpath.sv
`default_nettype none

module cfa_dpath #(
   parameter int ANGLE_FRAC_BITS = cfa_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int ANGLE_WIDTH     = cfa_pkg::ANGLE_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire cfa_pkg::cmd_type                    cmd,
   input  wire logic                                csr_wr,
   input  wire logic [cfa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [cfa_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic signed [cfa_pkg::SAMPLE_W-1:0] accel_x,
   input  wire logic signed [cfa_pkg::SAMPLE_W-1:0] accel_y,
   input  wire logic signed [cfa_pkg::SAMPLE_W-1:0] accel_z,
   input  wire logic signed [cfa_pkg::SAMPLE_W-1:0] rate_x,
   input  wire logic signed [cfa_pkg::SAMPLE_W-1:0] rate_y,
   input  wire logic signed [cfa_pkg::SAMPLE_W-1:0] rate_z,
   output logic signed [ANGLE_WIDTH-1:0]            roll_out,
   output logic signed [ANGLE_WIDTH-1:0]            pitch_out,
   output logic signed [ANGLE_WIDTH-1:0]            yaw_out
);

   localparam int SW       = cfa_pkg::SAMPLE_W;
   localparam int AW       = ANGLE_WIDTH;
   localparam int RND_SH   = cfa_pkg::Q16_FRAC - ANGLE_FRAC_BITS;
   localparam int RND_HALF = (RND_SH == 0) ? 0 : (1 << (RND_SH - 1));
   // sample + sign of negation, times 256, plus rotation gain headroom
   localparam int CW       = SW + 11;
   localparam int ZW       = 26;
   localparam int GP_W     = 2 * SW + 1;
   localparam int GT_W     = GP_W - RND_SH;
   localparam int GSUM_W   = ((AW > GT_W) ? AW : GT_W) + 1;
   localparam int ACC_W    = ZW - RND_SH;
   localparam int DW       = ((GSUM_W > ACC_W) ? GSUM_W : ACC_W) + 1;
   localparam int PW       = DW + cfa_pkg::CSR_DATA_W + 1;
   localparam int SUM_W    = PW + 1;
   localparam int Q_W      = SUM_W - cfa_pkg::Q16_FRAC;
   localparam int BL_HALF  = 1 << (cfa_pkg::Q16_FRAC - 1);

   localparam logic signed [ZW-1:0]  DEG180  = ZW'(cfa_pkg::DEG180_Q16);
   localparam logic signed [Q_W-1:0] ANG_MAX = {{(Q_W-AW+1){1'b0}}, {(AW-1){1'b1}}};
   localparam logic signed [Q_W-1:0] ANG_MIN = {{(Q_W-AW+1){1'b1}}, {(AW-1){1'b0}}};

   // Configuration
   logic [cfa_pkg::CSR_DATA_W-1:0] weight_ff, weight_in;
   logic [cfa_pkg::CSR_DATA_W-1:0] scale_ff, scale_in;

   // Rotation lanes: 0 is roll, 1 is pitch
   logic signed [CW-1:0] x_ff [2];
   logic signed [CW-1:0] x_in [2];
   logic signed [CW-1:0] y_ff [2];
   logic signed [CW-1:0] y_in [2];
   logic signed [ZW-1:0] z_ff [2];
   logic signed [ZW-1:0] z_in [2];
   logic                 zero_ff [2];
   logic                 zero_in [2];

   // Gyro path, one per axis
   logic signed [SW-1:0]     rate_ff  [3];
   logic signed [SW-1:0]     rate_in  [3];
   logic signed [GP_W-1:0]   gprod_ff [3];
   logic signed [GP_W-1:0]   gprod_in [3];
   logic signed [GSUM_W-1:0] gsum_ff  [3];
   logic signed [GSUM_W-1:0] gsum_in  [3];
   logic signed [GT_W-1:0]   gt       [3];

   // Blend
   logic signed [DW-1:0]    d_ff, d_in;
   logic signed [ACC_W-1:0] accsel_ff, accsel_in;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [AW-1:0]    angle_ff [3];
   logic signed [AW-1:0]    angle_in [3];

   logic signed [AW-1:0] roll_ff, roll_in;
   logic signed [AW-1:0] pitch_ff, pitch_in;
   logic signed [AW-1:0] yaw_ff, yaw_in;

   logic signed [SW:0]      xin;
   logic signed [SW:0]      yin [2];
   logic signed [CW-1:0]    x_sc;
   logic signed [CW-1:0]    y_sc;
   logic signed [ZW-1:0]    step_ang;
   logic signed [CW-1:0]    xsh;
   logic signed [CW-1:0]    ysh;
   logic signed [ACC_W-1:0] acc_rnd [2];
   logic signed [ACC_W-1:0] acc_pick;
   logic signed [SW:0]      w_s;
   logic signed [SUM_W-1:0] blend_sum;
   logic signed [Q_W-1:0]   blend_q;
   logic signed [AW-1:0]    blend_sat;

   // Register writes
   always_comb begin
      weight_in = weight_ff;
      scale_in  = scale_ff;
      if (csr_wr) begin
         unique case (csr_index)
            cfa_pkg::CSR_BLEND_WEIGHT:    weight_in = csr_wdata;
            cfa_pkg::CSR_RATE_STEP_SCALE: scale_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // Rotation lanes
   always_comb begin
      xin      = {accel_z[SW-1], accel_z};
      yin[0]   = {accel_y[SW-1], accel_y};
      yin[1]   = -{accel_x[SW-1], accel_x};
      step_ang = ZW'(cfa_pkg::atan_q16(cmd.step));
      x_sc     = '0;
      y_sc     = '0;
      xsh      = '0;
      ysh      = '0;
      for (int k = 0; k < 2; k++) begin
         x_in[k]    = x_ff[k];
         y_in[k]    = y_ff[k];
         z_in[k]    = z_ff[k];
         zero_in[k] = zero_ff[k];
         if (cmd.load) begin
            x_sc       = CW'(xin) <<< 8;
            y_sc       = CW'(yin[k]) <<< 8;
            zero_in[k] = (xin == '0) && (yin[k] == '0);
            if (xin < 0) begin
               x_in[k] = -x_sc;
               y_in[k] = -y_sc;
               z_in[k] = (yin[k] >= 0) ? DEG180 : -DEG180;
            end else begin
               x_in[k] = x_sc;
               y_in[k] = y_sc;
               z_in[k] = '0;
            end
         end else if (cmd.rot) begin
            xsh = x_ff[k] >>> cmd.step;
            ysh = y_ff[k] >>> cmd.step;
            // rotate towards the x axis
            if (y_ff[k] > 0) begin
               x_in[k] = x_ff[k] + ysh;
               y_in[k] = y_ff[k] - xsh;
               z_in[k] = z_ff[k] + step_ang;
            end else begin
               x_in[k] = x_ff[k] - ysh;
               y_in[k] = y_ff[k] + xsh;
               z_in[k] = z_ff[k] - step_ang;
            end
         end
      end
      for (int k = 0; k < 2; k++) begin
         acc_rnd[k] = zero_ff[k] ? '0 : ACC_W'((z_ff[k] + ZW'(RND_HALF)) >>> RND_SH);
      end
   end

   // Gyro path: runs during rotation, forming the scaled rate product and then the angle sum
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         gt[k] = GT_W'((gprod_ff[k] + GP_W'(RND_HALF)) >>> RND_SH);
         if (cmd.load) begin
            rate_in[k] = '0;
         end else begin
            rate_in[k] = rate_ff[k];
         end
         gprod_in[k] = gprod_ff[k];
         gsum_in[k]  = gsum_ff[k];
         if (cmd.rot) begin
            gprod_in[k] = rate_ff[k] * $signed({1'b0, scale_ff});
            gsum_in[k]  = GSUM_W'(angle_ff[k]) + GSUM_W'(gt[k]);
         end
      end
      if (cmd.load) begin
         rate_in[0] = rate_x;
         rate_in[1] = rate_y;
         rate_in[2] = rate_z;
      end
   end

   // Blend: one axis at a time through a shared multiplier
   //   w*g + (1-w)*a = w*(g-a) + a
   always_comb begin
      unique case (cmd.axis)
         cfa_pkg::AXIS_ROLL:  acc_pick = acc_rnd[0];
         cfa_pkg::AXIS_PITCH: acc_pick = acc_rnd[1];
         default:             acc_pick = '0;
      endcase
      w_s       = $signed({1'b0, weight_ff});
      d_in      = cmd.dif ? (DW'(gsum_ff[cmd.axis]) - DW'(acc_pick)) : d_ff;
      accsel_in = cmd.dif ? acc_pick : accsel_ff;
      prod_in   = cmd.mul ? (w_s * d_ff) : prod_ff;
      blend_sum = SUM_W'(prod_ff) + (SUM_W'(accsel_ff) <<< cfa_pkg::Q16_FRAC)
                  + SUM_W'(BL_HALF);
      blend_q   = Q_W'(blend_sum >>> cfa_pkg::Q16_FRAC);
      if (blend_q > ANG_MAX) begin
         blend_sat = ANG_MAX[AW-1:0];
      end else if (blend_q < ANG_MIN) begin
         blend_sat = ANG_MIN[AW-1:0];
      end else begin
         blend_sat = blend_q[AW-1:0];
      end
      for (int k = 0; k < 3; k++) begin
         angle_in[k] = angle_ff[k];
      end
      if (cmd.acc) begin
         angle_in[cmd.axis] = blend_sat;
      end
      roll_in  = cmd.out_load ? angle_ff[0] : roll_ff;
      pitch_in = cmd.out_load ? angle_ff[1] : pitch_ff;
      yaw_in   = cmd.out_load ? angle_ff[2] : yaw_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= cfa_pkg::BLEND_WEIGHT_RST;
         scale_ff  <= cfa_pkg::RATE_STEP_SCALE_RST;
         for (int k = 0; k < 3; k++) begin
            angle_ff[k] <= '0;
         end
      end else begin
         weight_ff <= weight_in;
         scale_ff  <= scale_in;
         for (int k = 0; k < 3; k++) begin
            angle_ff[k] <= angle_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 2; k++) begin
         x_ff[k]    <= x_in[k];
         y_ff[k]    <= y_in[k];
         z_ff[k]    <= z_in[k];
         zero_ff[k] <= zero_in[k];
      end
      for (int k = 0; k < 3; k++) begin
         rate_ff[k]  <= rate_in[k];
         gprod_ff[k] <= gprod_in[k];
         gsum_ff[k]  <= gsum_in[k];
      end
      d_ff      <= d_in;
      accsel_ff <= accsel_in;
      prod_ff   <= prod_in;
      roll_ff   <= roll_in;
      pitch_ff  <= pitch_in;
      yaw_ff    <= yaw_in;
   end

   assign roll_out  = roll_ff;
   assign pitch_out = pitch_ff;
   assign yaw_out   = yaw_ff;

endmodule

`default_nettype wire

### design/cfa_ctrl.sv
`default_nettype none

module cfa_ctrl #(
   parameter int CORDIC_STEPS = cfa_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output cfa_pkg::cmd_type cmd
);

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_ROT  = 6'b000010,
      S_DIF  = 6'b000100,
      S_MUL  = 6'b001000,
      S_ACC  = 6'b010000,
      S_OUT  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   cfa_pkg::axis_type axis_ff, axis_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_ROT;
               step_in  = '0;
            end
         end
         S_ROT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = S_DIF;
               axis_in  = cfa_pkg::AXIS_ROLL;
            end
         end
         S_DIF: state_in = S_MUL;
         S_MUL: state_in = S_ACC;
         S_ACC: begin
            if (axis_ff == cfa_pkg::AXIS_YAW) begin
               state_in = S_OUT;
            end else begin
               state_in = S_DIF;
               axis_in  = (axis_ff == cfa_pkg::AXIS_ROLL) ? cfa_pkg::AXIS_PITCH
                                                          : cfa_pkg::AXIS_YAW;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.load     = (state_ff == S_IDLE) && req_valid;
      cmd.rot      = (state_ff == S_ROT);
      cmd.dif      = (state_ff == S_DIF);
      cmd.mul      = (state_ff == S_MUL);
      cmd.acc      = (state_ff == S_ACC);
      cmd.out_load = (state_ff == S_OUT) && out_free;
      cmd.step     = cfa_pkg::TAB_IDX_W'(step_ff);
      cmd.axis     = axis_ff;

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         axis_ff      <= cfa_pkg::AXIS_ROLL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts_rot: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_ROT && step_ff == '0))
      else $error("accepted beat did not start the rotation");

   a_rot_to_blend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT && step_ff == LAST_STEP)
      |=> (state_ff == S_DIF && axis_ff == cfa_pkg::AXIS_ROLL))
      else $error("rotation did not hand over to the roll blend");

   a_yaw_then_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC && axis_ff == cfa_pkg::AXIS_YAW) |=> (state_ff == S_OUT))
      else $error("blend finished without presenting a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.out_load)
      else $error("result register overwritten while a beat waits");
`endif

endmodule

`default_nettype wire

### design/complementary_filter_attitude_unit.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  accel_x/y/z, rate_x/y/z (16 b signed)
// rsp      out        rsp_valid / rsp_ready  roll/pitch/yaw_out (ANGLE_WIDTH b signed)
// csr      in         csr_valid / csr_ready  csr_index (2 b), csr_wdata (16 b)
//
// A beat runs from acceptance through a load cycle, one micro-rotation per cycle on both
// arctangent lanes, the difference, multiply and accumulate states for each axis through the
// shared blend multiplier, and the move into the output register.
// A finished result waits in the output register while the next beat is taken; only the
// hand-over of the following result stalls on rsp_ready.
// Reset returns the angles to zero and the registers to their defaults; csr_ready stays high.

module complementary_filter_attitude_unit #(
   parameter int ANGLE_FRAC_BITS = cfa_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int ANGLE_WIDTH     = cfa_pkg::ANGLE_WIDTH_DEF,
   parameter int CORDIC_STEPS    = cfa_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [cfa_pkg::SAMPLE_W-1:0] req_accel_x,
   input  wire logic signed [cfa_pkg::SAMPLE_W-1:0] req_accel_y,
   input  wire logic signed [cfa_pkg::SAMPLE_W-1:0] req_accel_z,
   input  wire logic signed [cfa_pkg::SAMPLE_W-1:0] req_rate_x,
   input  wire logic signed [cfa_pkg::SAMPLE_W-1:0] req_rate_y,
   input  wire logic signed [cfa_pkg::SAMPLE_W-1:0] req_rate_z,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [ANGLE_WIDTH-1:0]            rsp_roll_out,
   output logic signed [ANGLE_WIDTH-1:0]            rsp_pitch_out,
   output logic signed [ANGLE_WIDTH-1:0]            rsp_yaw_out,

   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cfa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [cfa_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   cfa_pkg::cmd_type cmd;

   // Register writes are taken in any cycle
   assign csr_ready = 1'b1;

   // Sequencer: load, rotate, blend each axis, hand over the result
   cfa_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Arithmetic: arctangent lanes, gyro integration, blend and output register
   cfa_dpath #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .ANGLE_WIDTH     (ANGLE_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accel_x   (req_accel_x),
      .accel_y   (req_accel_y),
      .accel_z   (req_accel_z),
      .rate_x    (req_rate_x),
      .rate_y    (req_rate_y),
      .rate_z    (req_rate_z),
      .roll_out  (rsp_roll_out),
      .pitch_out (rsp_pitch_out),
      .yaw_out   (rsp_yaw_out)
   );

endmodule

`default_nettype wire

### tb/complementary_filter_attitude_unit_test.sv
`timescale 1ns / 1ps

module complementary_filter_attitude_unit_test;

   // Geometry of the instance under test (package defaults)
   localparam int ANGLE_W   = cfa_pkg::ANGLE_WIDTH_DEF;
   localparam int FRAC      = cfa_pkg::ANGLE_FRAC_BITS_DEF;
   localparam int STEPS     = cfa_pkg::CORDIC_STEPS_DEF;
   localparam int DROP_BITS = 16 - FRAC;

   // Cycles from one accepted beat to the next, used for the closing quiet period
   localparam int BEAT_CYCLES    = STEPS + 11;
   localparam int TAIL_CYCLES    = 2 * BEAT_CYCLES;
   localparam int WATCHDOG_LIMIT = 2000;

   // Register indexes that the block has no register behind
   localparam logic [cfa_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [cfa_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   // atan(2^-i) in Q.16 degrees, and half a turn in the same scale
   localparam longint HALF_TURN_Q16 = 11796480;
   localparam longint ATAN_DEG_Q16 [24] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct packed {
      logic signed [cfa_pkg::SAMPLE_W-1:0] accel_x;
      logic signed [cfa_pkg::SAMPLE_W-1:0] accel_y;
      logic signed [cfa_pkg::SAMPLE_W-1:0] accel_z;
      logic signed [cfa_pkg::SAMPLE_W-1:0] rate_x;
      logic signed [cfa_pkg::SAMPLE_W-1:0] rate_y;
      logic signed [cfa_pkg::SAMPLE_W-1:0] rate_z;
   } imu_sample_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] roll;
      logic [ANGLE_W-1:0] pitch;
      logic [ANGLE_W-1:0] yaw;
   } angle_set_type;

   // Attitude predictor and the queue of angles still owed by the block
   class attitude_scoreboard;
      angle_set_type pending[$];
      longint        roll_q;
      longint        pitch_q;
      longint        yaw_q;
      longint        weight;
      longint        step_scale;
      int            errors;
      int            checked;

      function new();
         roll_q     = 0;
         pitch_q    = 0;
         yaw_q      = 0;
         weight     = cfa_pkg::BLEND_WEIGHT_RST;
         step_scale = cfa_pkg::RATE_STEP_SCALE_RST;
         errors     = 0;
         checked    = 0;
      endfunction

      function void write_reg(logic [cfa_pkg::CSR_IDX_W-1:0] idx,
                              logic [cfa_pkg::CSR_DATA_W-1:0] val);
         unique case (idx)
            cfa_pkg::CSR_BLEND_WEIGHT:    weight = val;
            cfa_pkg::CSR_RATE_STEP_SCALE: step_scale = val;
            default:                      ;
         endcase
      endfunction

      function longint to_angle_lsb(longint v_q16);
         if (DROP_BITS == 0)
            return v_q16;
         return (v_q16 + (longint'(1) << (DROP_BITS - 1))) >>> DROP_BITS;
      endfunction

      function longint clamp_angle(longint v);
         longint hi;
         longint lo;
         hi = (longint'(1) << (ANGLE_W - 1)) - 1;
         lo = -(longint'(1) << (ANGLE_W - 1));
         if (v > hi)
            return hi;
         if (v < lo)
            return lo;
         return v;
      endfunction

      function longint rate_increment(logic signed [cfa_pkg::SAMPLE_W-1:0] rate);
         return to_angle_lsb(longint'(rate) * step_scale);
      endfunction

      // atan2(y, x) in degrees, vectoring towards y = 0
      function longint cordic_heading(longint y_in, longint x_in);
         longint x;
         longint y;
         longint z;
         longint xs;
         longint ys;
         if (x_in == 0 && y_in == 0)
            return 0;
         x = x_in * 256;
         y = y_in * 256;
         z = 0;
         if (x < 0) begin
            z = (y >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x = x + ys;
               y = y - xs;
               z = z + ATAN_DEG_Q16[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - ATAN_DEG_Q16[i];
            end
         end
         return to_angle_lsb(z);
      endfunction

      function longint mix(longint gyro, longint accel, bit with_accel);
         longint s;
         s = weight * gyro + 32768;
         if (with_accel)
            s = s + (65536 - weight) * accel;
         return clamp_angle(s >>> 16);
      endfunction

      function void note_sample(imu_sample_type s);
         longint        roll_g;
         longint        pitch_g;
         longint        yaw_g;
         longint        roll_a;
         longint        pitch_a;
         angle_set_type want;
         roll_g  = roll_q + rate_increment(s.rate_x);
         pitch_g = pitch_q + rate_increment(s.rate_y);
         yaw_g   = yaw_q + rate_increment(s.rate_z);
         roll_a  = cordic_heading(longint'(s.accel_y), longint'(s.accel_z));
         pitch_a = cordic_heading(-longint'(s.accel_x), longint'(s.accel_z));
         roll_q  = mix(roll_g, roll_a, 1'b1);
         pitch_q = mix(pitch_g, pitch_a, 1'b1);
         yaw_q   = mix(yaw_g, 0, 1'b0);
         want.roll  = roll_q[ANGLE_W-1:0];
         want.pitch = pitch_q[ANGLE_W-1:0];
         want.yaw   = yaw_q[ANGLE_W-1:0];
         pending.push_back(want);
      endfunction

      task report(string what, logic [ANGLE_W-1:0] got, logic [ANGLE_W-1:0] want);
         errors++;
         $display("mismatch, %s: got %0d want %0d (result %0d)",
                  what, $signed(got), $signed(want), checked);
      endtask

      task check_result(logic [ANGLE_W-1:0] roll, logic [ANGLE_W-1:0] pitch,
                        logic [ANGLE_W-1:0] yaw);
         angle_set_type want;
         if (pending.size() == 0) begin
            report("result with nothing owed, roll_out", roll, '0);
            return;
         end
         want = pending.pop_front();
         checked++;
         if (roll !== want.roll)
            report("roll_out", roll, want.roll);
         if (pitch !== want.pitch)
            report("pitch_out", pitch, want.pitch);
         if (yaw !== want.yaw)
            report("yaw_out", yaw, want.yaw);
      endtask
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic signed [cfa_pkg::SAMPLE_W-1:0] req_accel_x;
   logic signed [cfa_pkg::SAMPLE_W-1:0] req_accel_y;
   logic signed [cfa_pkg::SAMPLE_W-1:0] req_accel_z;
   logic signed [cfa_pkg::SAMPLE_W-1:0] req_rate_x;
   logic signed [cfa_pkg::SAMPLE_W-1:0] req_rate_y;
   logic signed [cfa_pkg::SAMPLE_W-1:0] req_rate_z;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [ANGLE_W-1:0]           rsp_roll_out;
   logic signed [ANGLE_W-1:0]           rsp_pitch_out;
   logic signed [ANGLE_W-1:0]           rsp_yaw_out;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [cfa_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [cfa_pkg::CSR_DATA_W-1:0]      csr_wdata;

   attitude_scoreboard sb;
   bit gaps_on;
   int n_samples;
   int n_settings;

   complementary_filter_attitude_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_accel_x   (req_accel_x),
      .req_accel_y   (req_accel_y),
      .req_accel_z   (req_accel_z),
      .req_rate_x    (req_rate_x),
      .req_rate_y    (req_rate_y),
      .req_rate_z    (req_rate_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_roll_out  (rsp_roll_out),
      .rsp_pitch_out (rsp_pitch_out),
      .rsp_yaw_out   (rsp_yaw_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side: hold rsp_ready low at random, about 8 percent of the time, while gaps are on
   always @(negedge clock) begin
      rsp_ready <= !gaps_on || ($urandom_range(0, 99) >= 8);
   end

   // Take each result beat at the rising edge and compare it with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_roll_out, rsp_pitch_out, rsp_yaw_out);
   end

   // Abort when no channel has moved a beat for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic imu_sample_type make_sample(input int ax, input int ay, input int az,
                                                  input int rx, input int ry, input int rz);
      imu_sample_type s;
      s.accel_x = ax[15:0];
      s.accel_y = ay[15:0];
      s.accel_z = az[15:0];
      s.rate_x  = rx[15:0];
      s.rate_y  = ry[15:0];
      s.rate_z  = rz[15:0];
      return s;
   endfunction

   // Full-scale, zero, one-off-zero or random values; these hit the zero vector and the
   // half-turn cases of the arctangent often enough
   function automatic logic [15:0] corner_value();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         4:       return 16'h0001;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] spread(input int span);
      int v;
      v = int'($urandom_range(0, 2 * span)) - span;
      return v[15:0];
   endfunction

   // Most often plausible motion (moderate gravity vector, modest rates), otherwise raw
   // noise across every bit or corner-heavy samples
   function automatic imu_sample_type random_sample();
      imu_sample_type s;
      int             pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         s.accel_x = spread(20000);
         s.accel_y = spread(20000);
         s.accel_z = spread(20000);
         s.rate_x  = spread(2000);
         s.rate_y  = spread(2000);
         s.rate_z  = spread(2000);
      end else if (pick < 80) begin
         s = imu_sample_type'({$urandom, $urandom, $urandom});
      end else begin
         s.accel_x = corner_value();
         s.accel_y = corner_value();
         s.accel_z = corner_value();
         s.rate_x  = corner_value();
         s.rate_y  = corner_value();
         s.rate_z  = corner_value();
      end
      return s;
   endfunction

   // Enter and leave at a falling edge. Valid is only dropped for an idle gap,
   // so back-to-back beats keep it high.
   task automatic send_sample(input imu_sample_type s);
      if (gaps_on)
         while ($urandom_range(0, 99) < 8) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      req_valid   <= 1'b1;
      req_accel_x <= s.accel_x;
      req_accel_y <= s.accel_y;
      req_accel_z <= s.accel_z;
      req_rate_x  <= s.rate_x;
      req_rate_y  <= s.rate_y;
      req_rate_z  <= s.rate_z;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(s);
      n_samples++;
      @(negedge clock);
   endtask

   task automatic run_random(input int count);
      repeat (count) send_sample(random_sample());
   endtask

   // Hold the sender until every owed result has been taken; the block is then idle
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending.size() != 0);
   endtask

   task automatic csr_beat(input logic [cfa_pkg::CSR_IDX_W-1:0] idx,
                           input logic [cfa_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   // Write both registers, then poke the unused indexes, which must change nothing
   task automatic program_regs(input logic [cfa_pkg::CSR_DATA_W-1:0] weight,
                               input logic [cfa_pkg::CSR_DATA_W-1:0] scale);
      csr_beat(cfa_pkg::CSR_BLEND_WEIGHT, weight);
      csr_beat(cfa_pkg::CSR_RATE_STEP_SCALE, scale);
      csr_beat(CSR_SPARE_A, 16'($urandom));
      csr_beat(CSR_SPARE_B, 16'($urandom));
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   initial begin
      sb          = new();
      gaps_on     = 1'b1;
      n_samples   = 0;
      n_settings  = 1;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      req_rate_x  = '0;
      req_rate_y  = '0;
      req_rate_z  = '0;
      rsp_ready   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = cfa_pkg::CSR_BLEND_WEIGHT;
      csr_wdata   = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: the arctangent special cases and full-scale corners
      send_sample(make_sample(0, 0, 0, 0, 0, 0));                 // zero vector, both lanes
      send_sample(make_sample(0, 0, -16384, 0, 0, 0));            // negative x, y exactly zero
      send_sample(make_sample(0, -1, -16384, 1, -1, 1));          // negative x, y just below zero
      send_sample(make_sample(1, 1, -16384, -1, 1, -1));          // negative x, y just above zero
      send_sample(make_sample(16384, 0, 0, 0, 0, 0));             // x zero, y non-zero
      send_sample(make_sample(0, 32767, 0, 0, 0, 0));
      send_sample(make_sample(0, -32768, 0, 0, 0, 0));
      send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
      send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
      send_sample(make_sample(-32768, 32767, -32768, 32767, -32768, 0));
      send_sample(make_sample(32767, -32768, 1, 0, 32767, -32768));
      send_sample(make_sample(0, 0, 16384, 32767, 32767, 32767));
      send_sample(make_sample(0, 0, 16384, -32768, -32768, -32768));
      send_sample(make_sample(1, -1, 32767, 1, -1, 0));
      send_sample(make_sample('h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA));
      send_sample(make_sample('hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555));
      drain();

      // Full weight and full step: drive all three angles into both rails
      program_regs(16'hFFFF, 16'hFFFF);
      repeat (4) send_sample(make_sample(0, 0, 16384, 32767, 32767, 32767));
      repeat (4) send_sample(make_sample(0, 0, 16384, -32768, -32768, -32768));
      run_random(120);
      drain();

      // Zero weight and zero step: output follows the accelerometer alone, yaw collapses
      program_regs(16'h0000, 16'h0000);
      run_random(120);
      drain();

      // Random setting with no idling on either side; pause the sender half way
      // until every result is back
      program_regs(16'($urandom), 16'($urandom));
      gaps_on = 1'b0;
      run_random(100);
      drain();
      run_random(100);
      drain();
      gaps_on = 1'b1;

      // A few more random settings, the last one back at the reset values
      for (int k = 0; k < 4; k++) begin
         if (k == 3)
            program_regs(cfa_pkg::BLEND_WEIGHT_RST, cfa_pkg::RATE_STEP_SCALE_RST);
         else
            program_regs(16'($urandom), 16'($urandom));
         run_random(100);
         drain();
      end

      // Let a stray late result show up before closing
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d samples over %0d register settings, %0d results checked,",
               n_samples, n_settings, sb.checked);
      $display("including both arctangent half-turn cases, zero vectors and angle saturation");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
design/cfa_pkg.sv
design/cfa_dpath.sv
design/cfa_ctrl.sv
design/complementary_filter_attitude_unit.sv
tb/complementary_filter_attitude_unit_test.sv
